>>> hdl/drau_pkg.sv
// Package for the dyadic rational arithmetic unit: field widths, the command
// encoding and the structs that travel between the pipeline stages.
// Depends on nothing; every other file of the unit imports it.
package drau_pkg;

  localparam int unsigned NumW   = 64;
  localparam int unsigned PowW   = 6;
  localparam int unsigned WideW  = 2 * NumW;
  // Largest result power that can be represented.
  localparam int unsigned MaxPower = 63;

  typedef enum logic [1:0] {
    CmdAdd      = 2'd0,
    CmdLess     = 2'd1,
    CmdSumLeOne = 2'd2,
    CmdMid      = 2'd3
  } cmd_e;

  // Operands as they arrive on the request channel.
  typedef struct packed {
    cmd_e              cmd;
    logic [NumW-1:0]   a_num;
    logic [PowW-1:0]   a_pow;
    logic [NumW-1:0]   b_num;
    logic [PowW-1:0]   b_pow;
  } req_t;

  // After alignment to the larger power.
  typedef struct packed {
    cmd_e              cmd;
    logic [WideW-1:0]  a_wide;
    logic [WideW-1:0]  b_wide;
    logic [PowW-1:0]   max_pow;
    logic              same_pow;
  } align_t;

  // After the wide add and the exact compare.
  typedef struct packed {
    cmd_e              cmd;
    logic [NumW-1:0]   sum_lo;
    logic              sum_hi_nz;
    logic              less;
    logic [PowW-1:0]   max_pow;
    logic              same_pow;
  } sum_t;

  // After trailing-zero removal.
  typedef struct packed {
    cmd_e              cmd;
    logic [NumW-1:0]   stripped;
    logic [PowW-1:0]   tz;
    logic              sum_hi_nz;
    logic              flag;
    logic [PowW-1:0]   max_pow;
  } strip_t;

  // One result item.
  typedef struct packed {
    logic [NumW-1:0]   res_numerator;
    logic [PowW-1:0]   res_power;
    logic              flag;
    logic              overflow;
  } res_t;

endpackage

>>> hdl/drau_if.sv
// Channel interfaces of the dyadic rational arithmetic unit: the request
// channel carrying the operands and the response channel carrying results.
// Depends on drau_pkg for the field widths.
interface drau_req_if import drau_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [NumW-1:0]   a_numerator;
  logic [PowW-1:0]   a_power;
  logic [NumW-1:0]   b_numerator;
  logic [PowW-1:0]   b_power;

  modport source (output valid, cmd, a_numerator, a_power, b_numerator, b_power,
                  input ready);
  modport sink   (input valid, cmd, a_numerator, a_power, b_numerator, b_power,
                  output ready);
endinterface

interface drau_rsp_if import drau_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NumW-1:0]   res_numerator;
  logic [PowW-1:0]   res_power;
  logic              flag;
  logic              overflow;

  modport source (output valid, res_numerator, res_power, flag, overflow,
                  input ready);
  modport sink   (input valid, res_numerator, res_power, flag, overflow,
                  output ready);
endinterface

>>> hdl/drau_align_stage.sv
// First pipeline stage: shifts the operand with the smaller power left so
// both numerators share the larger power. Depends on drau_pkg.
module drau_align_stage import drau_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  req_t   data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output align_t data_o
);

  logic   valid_q;
  align_t data_d, data_q;
  logic [PowW-1:0] max_pow, a_sh, b_sh;

  always_comb begin
    max_pow = (data_i.a_pow > data_i.b_pow) ? data_i.a_pow : data_i.b_pow;
    a_sh    = max_pow - data_i.a_pow;
    b_sh    = max_pow - data_i.b_pow;
    data_d.cmd      = data_i.cmd;
    data_d.a_wide   = {{(WideW-NumW){1'b0}}, data_i.a_num} << a_sh;
    data_d.b_wide   = {{(WideW-NumW){1'b0}}, data_i.b_num} << b_sh;
    data_d.max_pow  = max_pow;
    data_d.same_pow = (data_i.a_pow == data_i.b_pow);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hdl/drau_sum_stage.sv
// Second pipeline stage: the 128-bit sum of the aligned numerators and the
// exact less-than compare between them. Depends on drau_pkg.
module drau_sum_stage import drau_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  align_t data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output sum_t   data_o
);

  logic             valid_q;
  sum_t             data_d, data_q;
  logic [WideW-1:0] sum;

  always_comb begin
    sum = data_i.a_wide + data_i.b_wide;
    data_d.cmd       = data_i.cmd;
    data_d.sum_lo    = sum[NumW-1:0];
    data_d.sum_hi_nz = |sum[WideW-1:NumW];
    data_d.less      = (data_i.a_wide < data_i.b_wide);
    data_d.max_pow   = data_i.max_pow;
    data_d.same_pow  = data_i.same_pow;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hdl/drau_strip_stage.sv
// Third pipeline stage: removes trailing zero bits of an equal-power sum and
// settles the comparison flag. Depends on drau_pkg.
module drau_strip_stage import drau_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  sum_t   data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output strip_t data_o
);

  logic            valid_q;
  strip_t          data_d, data_q;
  logic [NumW-1:0] x;
  logic [PowW-1:0] t;
  logic            le_one;

  always_comb begin
    // Binary search for the lowest set bit, halving the window each step.
    x = data_i.sum_lo;
    t = '0;
    for (int i = PowW - 1; i >= 0; i--) begin
      if ((x & ((64'd1 << (1 << i)) - 64'd1)) == '0) begin
        x    = x >> (1 << i);
        t[i] = 1'b1;
      end
    end
    // Only a sum of equal powers is reduced, and a zero sum is left alone.
    if (!data_i.same_pow || (data_i.sum_lo == '0)) begin
      x = data_i.sum_lo;
      t = '0;
    end

    le_one = !data_i.sum_hi_nz && (data_i.sum_lo <= (64'd1 << data_i.max_pow));

    data_d.cmd       = data_i.cmd;
    data_d.stripped  = x;
    data_d.tz        = t;
    data_d.sum_hi_nz = data_i.sum_hi_nz;
    data_d.max_pow   = data_i.max_pow;
    case (data_i.cmd)
      CmdLess:     data_d.flag = data_i.less;
      CmdSumLeOne: data_d.flag = le_one;
      default:     data_d.flag = 1'b0;
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hdl/drau_result_stage.sv
// Last pipeline stage and output register: result power, overflow detection
// and zeroing of failed results. Depends on drau_pkg.
module drau_result_stage import drau_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  strip_t data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output res_t   data_o
);

  logic          valid_q;
  res_t          data_d, data_q;
  logic [PowW:0] pow_ext;
  logic          ovf;

  always_comb begin
    pow_ext = {1'b0, data_i.max_pow} - {1'b0, data_i.tz}
              + {{PowW{1'b0}}, (data_i.cmd == CmdMid)};
    ovf     = data_i.sum_hi_nz || (data_i.tz > data_i.max_pow)
              || (pow_ext > (PowW + 1)'(MaxPower));
    data_d  = '0;
    case (data_i.cmd)
      CmdAdd, CmdMid: begin
        data_d.overflow = ovf;
        if (!ovf) begin
          data_d.res_numerator = data_i.stripped;
          data_d.res_power     = pow_ext[PowW-1:0];
        end
      end
      CmdLess, CmdSumLeOne: begin
        data_d.flag = data_i.flag;
      end
      default: begin
        data_d = '0;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> hdl/dyadic_rational_alu_unit.sv
// Top level of the dyadic rational arithmetic unit: a four-stage pipeline
// built from the align, sum, strip and result stages. Depends on drau_pkg and
// the channel interfaces in drau_if.sv.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+-----------------------------------
//   req_i   | in        | valid/ready        | cmd, a/b numerator and power
//   rsp_o   | out       | valid/ready        | res_numerator, res_power, flag,
//           |           |                    | overflow
//
// One item is taken per cycle while rsp_o does not stall. There is one register
// for each of align, wide add, trailing-zero strip and result formatting, and
// the first one loads at the transfer edge on req_i. The item then passes the
// sum, strip and result registers in turn, the last one driving rsp_o.valid.
// Reset clears only the stage valid bits; payload registers are loaded on use.
// Each stage holds its item while the stage after it is full and stalled, so a
// stall on rsp_o fills the pipeline from the back while empty stages keep
// accepting; nothing is dropped or repeated.
module dyadic_rational_alu_unit import drau_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  drau_req_if.sink    req_i,
  drau_rsp_if.source  rsp_o
);

  req_t   req;
  align_t align_data;
  sum_t   sum_data;
  strip_t strip_data;
  res_t   res_data;

  logic align_valid, align_ready;
  logic sum_valid, sum_ready;
  logic strip_valid, strip_ready;

  // The request fields are gathered into one struct for the first stage.
  always_comb begin
    req.cmd   = cmd_e'(req_i.cmd);
    req.a_num = req_i.a_numerator;
    req.a_pow = req_i.a_power;
    req.b_num = req_i.b_numerator;
    req.b_pow = req_i.b_power;
  end

  // Stage one: bring both numerators to the larger power.
  drau_align_stage u_align (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .ready_o (req_i.ready),
    .data_i  (req),
    .valid_o (align_valid),
    .ready_i (align_ready),
    .data_o  (align_data)
  );

  // Stage two: 128-bit sum and exact compare.
  drau_sum_stage u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (align_valid),
    .ready_o (align_ready),
    .data_i  (align_data),
    .valid_o (sum_valid),
    .ready_i (sum_ready),
    .data_o  (sum_data)
  );

  // Stage three: strip trailing zeros and settle the comparison flag.
  drau_strip_stage u_strip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .ready_o (sum_ready),
    .data_i  (sum_data),
    .valid_o (strip_valid),
    .ready_i (strip_ready),
    .data_o  (strip_data)
  );

  // Stage four: power, overflow, and the output register itself.
  drau_result_stage u_result (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (strip_valid),
    .ready_o (strip_ready),
    .data_i  (strip_data),
    .valid_o (rsp_o.valid),
    .ready_i (rsp_o.ready),
    .data_o  (res_data)
  );

  assign rsp_o.res_numerator = res_data.res_numerator;
  assign rsp_o.res_power     = res_data.res_power;
  assign rsp_o.flag          = res_data.flag;
  assign rsp_o.overflow      = res_data.overflow;

  // A failed add or midpoint must come out as an all-zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.overflow |-> rsp_o.res_numerator == '0 && rsp_o.res_power == '0)
    else $error("overflowed result carries a nonzero value");

  // A set flag only comes from a comparison, which never overflows or has a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.flag |-> !rsp_o.overflow && rsp_o.res_numerator == '0)
    else $error("comparison flag set together with an arithmetic result");

  // The power of a delivered result never exceeds the largest representable one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> {1'b0, rsp_o.res_power} <= (PowW + 1)'(MaxPower))
    else $error("result power above the representable range");

  // A full, stalled pipeline must stop taking requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    align_valid && !align_ready |-> !req_i.ready)
    else $error("request taken while the first stage is blocked");

endmodule
